### rtl/mrg8_pkg.sv
// Shared types, constants and arithmetic helpers of the MRG8 generator.
`timescale 1ns / 1ps

package mrg8_pkg;

  localparam int unsigned RING_DEPTH = 8;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned RES_W   = 31;
  localparam int unsigned VALUE_W = 53;
  localparam int unsigned HI_W    = 23;
  localparam int unsigned LO_W    = 30;

  localparam logic [31:0] MOD32     = 32'h7FFF_FFFF;
  localparam logic [31:0] TWO_MOD32 = 32'hFFFF_FFFE;
  localparam logic [31:0] SEED_MUL  = 32'd1812433253;

  typedef enum logic [1:0] {
    OP_SEED = 2'd0,
    OP_INT  = 2'd1,
    OP_UNI  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_INT,
    RES_UNI,
    RES_STUCK,
    RES_NONE
  } res_kind_t;

  typedef struct packed {
    logic             rd_en;
    logic             rd_rel;    // address relative to the ring pointer
    logic             rd_chk;    // read feeds the stuck check, not the MAC
    logic             rd_last;
    logic [IDX_W-1:0] rd_k;
    logic             acc_clr;
    logic             chk_clr;
    logic             seed_load;
    logic             seed_mul;
    logic             seed_step;
    logic [IDX_W-1:0] seed_idx;
    logic             wr_acc;
    logic             cap_hi;
    logic             res_load;
    res_kind_t        res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic chk_done;
    logic all_zero;
    logic frac_zero;
    logic slot_free;
  } dp_sts_t;

  function automatic logic [RES_W-1:0] mrg8_coef(input logic [IDX_W-1:0] k);
    logic [RES_W-1:0] c;
    unique case (k)
      3'd0: c = 31'd1089656042;
      3'd1: c = 31'd1906537547;
      3'd2: c = 31'd1764115693;
      3'd3: c = 31'd1304127872;
      3'd4: c = 31'd189748160;
      3'd5: c = 31'd1984088114;
      3'd6: c = 31'd626062218;
      3'd7: c = 31'd1927846343;
    endcase
    return c;
  endfunction

  // 63-bit product mod 2^31-1 by two folds and one conditional subtract
  function automatic logic [RES_W-1:0] mrg8_reduce(input logic [62:0] p);
    logic [32:0] s;
    logic [31:0] t;
    s = {1'b0, p[62:31]} + {2'b0, p[30:0]};
    t = {30'b0, s[32:31]} + {1'b0, s[30:0]};
    if (t >= MOD32) t = t - MOD32;
    return t[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] mrg8_add_mod(input logic [RES_W-1:0] a,
                                                    input logic [RES_W-1:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD32) s = s - MOD32;
    return s[RES_W-1:0];
  endfunction

endpackage

### rtl/mrg8_if.sv
// Valid/ready channel interfaces for the MRG8 request and result words.
`timescale 1ns / 1ps

interface mrg8_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [30:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface mrg8_out_if;
  logic        valid;
  logic        ready;
  logic [52:0] value;
  logic        is_uniform;
  logic        stuck;

  modport source (output valid, output value, output is_uniform, output stuck,
                  input ready);
  modport sink   (input valid, input value, input is_uniform, input stuck,
                  output ready);
endinterface

### rtl/mrg8_dp.sv
// MRG8 datapath: history ring, shared multiplier, MAC pipeline, result register.
`timescale 1ns / 1ps

module mrg8_dp
  import mrg8_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [30:0]       seed_value,
  output dp_sts_t           sts,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [VALUE_W-1:0] rsp_value,
  output logic              rsp_is_uniform,
  output logic              rsp_stuck
);

  logic [WORD_W-1:0] ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [IDX_W-1:0]  ptr;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rdata;

  logic              s1_mac, s1_chk, s1_last;
  logic [IDX_W-1:0]  s1_k;
  logic              s2_valid, s2_last;
  logic              s3_valid, s3_last;

  logic [WORD_W-1:0] a_op, b_op, mix;
  logic [63:0]       mul_out, prod;
  logic [RES_W-1:0]  term, acc;
  logic [WORD_W-1:0] wreg, seed_next;
  logic [HI_W-1:0]   hi;
  logic              zero_all, rd_zero;
  logic              mac_done, chk_done;

  assign rd_addr   = cmd.rd_rel ? (ptr + IDX_LAST - cmd.rd_k) : cmd.rd_k;
  assign mix       = wreg ^ (wreg >> 30);
  assign a_op      = cmd.seed_mul ? SEED_MUL : {1'b0, mrg8_coef(s1_k)};
  assign b_op      = cmd.seed_mul ? mix : rdata;
  assign mul_out   = a_op * b_op;
  assign seed_next = prod[WORD_W-1:0] + {{(WORD_W-IDX_W){1'b0}}, cmd.seed_idx};
  // a word is zero mod M when it is 0, M or 2M
  assign rd_zero   = (rdata == '0) || (rdata == MOD32) || (rdata == TWO_MOD32);

  // ring storage; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      ring[0] <= {1'b0, seed_value};
    end else if (cmd.seed_step) begin
      ring[cmd.seed_idx] <= seed_next;
    end else if (cmd.wr_acc) begin
      ring[ptr] <= {1'b0, acc};
    end
    if (cmd.rd_en) begin
      rdata <= vld[rd_addr] ? ring[rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      ptr      <= '0;
      s1_mac   <= 1'b0;
      s1_chk   <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
      s3_valid <= 1'b0;
      s3_last  <= 1'b0;
      mac_done <= 1'b0;
      chk_done <= 1'b0;
      zero_all <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.seed_load) begin
        vld[0] <= 1'b1;
        ptr    <= '0;
      end else if (cmd.seed_step) begin
        vld[cmd.seed_idx] <= 1'b1;
      end else if (cmd.wr_acc) begin
        vld[ptr] <= 1'b1;
        ptr      <= ptr + 1'b1;
      end
      s1_mac   <= cmd.rd_en & ~cmd.rd_chk;
      s1_chk   <= cmd.rd_en & cmd.rd_chk;
      s1_last  <= cmd.rd_last;
      s2_valid <= s1_mac;
      s2_last  <= s1_last;
      s3_valid <= s2_valid;
      s3_last  <= s2_last;
      mac_done <= s3_valid & s3_last;
      chk_done <= s1_chk & s1_last;
      if (cmd.chk_clr) begin
        zero_all <= 1'b1;
      end else if (s1_chk) begin
        zero_all <= zero_all & rd_zero;
      end
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_k <= cmd.rd_k;
    if (cmd.seed_mul || s1_mac) begin
      prod <= mul_out;
    end
    if (s2_valid) begin
      term <= mrg8_reduce(prod[62:0]);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= mrg8_add_mod(acc, term);
    end
    if (cmd.seed_load) begin
      wreg <= {1'b0, seed_value};
    end else if (cmd.seed_step) begin
      wreg <= seed_next;
    end
    if (cmd.cap_hi) begin
      hi <= acc[HI_W-1:0];
    end
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        RES_INT: begin
          rsp_value      <= {{(VALUE_W-RES_W){1'b0}}, acc};
          rsp_is_uniform <= 1'b0;
          rsp_stuck      <= 1'b0;
        end
        RES_UNI: begin
          rsp_value      <= {hi, acc[LO_W-1:0]};
          rsp_is_uniform <= 1'b1;
          rsp_stuck      <= 1'b0;
        end
        RES_STUCK: begin
          rsp_value      <= '0;
          rsp_is_uniform <= 1'b1;
          rsp_stuck      <= 1'b1;
        end
        RES_NONE: begin
          rsp_value      <= '0;
          rsp_is_uniform <= 1'b0;
          rsp_stuck      <= 1'b0;
        end
      endcase
    end
  end

  assign sts.mac_done  = mac_done;
  assign sts.chk_done  = chk_done;
  assign sts.all_zero  = zero_all;
  assign sts.frac_zero = (hi == '0) && (acc[LO_W-1:0] == '0);
  assign sts.slot_free = ~rsp_valid | rsp_ready;

endmodule

### rtl/mrg8_ctrl.sv
// MRG8 controller: sequences seeding, stuck check, MAC draws and result load.
`timescale 1ns / 1ps

module mrg8_ctrl
  import mrg8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_opcode,
  output logic       req_ready,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_STEP,
    S_CHK_ISSUE,
    S_CHK_WAIT,
    S_MAC_ISSUE,
    S_MAC_WAIT,
    S_RESULT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] k;
  logic             uni;     // current draw belongs to a uniform pair
  logic             second;  // second draw of the pair
  res_kind_t        res_kind;
  op_t              op;

  assign op        = op_t'(req_opcode);
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.res_kind = res_kind;
    unique case (state)
      S_IDLE: begin
        cmd.seed_load = req_valid && (op == OP_SEED);
      end
      S_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
      end
      S_SEED_STEP: begin
        cmd.seed_step = 1'b1;
        cmd.seed_idx  = k;
      end
      S_CHK_ISSUE: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_chk  = 1'b1;
        cmd.rd_k    = k;
        cmd.rd_last = (k == IDX_LAST);
        cmd.chk_clr = (k == '0);
      end
      S_MAC_ISSUE: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_rel  = 1'b1;
        cmd.rd_k    = k;
        cmd.rd_last = (k == IDX_LAST);
        cmd.acc_clr = (k == '0);
      end
      S_MAC_WAIT: begin
        cmd.wr_acc = sts.mac_done;
        cmd.cap_hi = sts.mac_done & uni & ~second;
      end
      S_RESULT: begin
        cmd.res_load = sts.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k        <= '0;
      uni      <= 1'b0;
      second   <= 1'b0;
      res_kind <= RES_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            unique case (op)
              OP_SEED: begin
                k     <= IDX_W'(1);
                state <= S_SEED_MUL;
              end
              OP_INT: begin
                uni    <= 1'b0;
                second <= 1'b0;
                k      <= '0;
                state  <= S_MAC_ISSUE;
              end
              OP_UNI: begin
                k     <= '0;
                state <= S_CHK_ISSUE;
              end
              OP_NONE: begin
                res_kind <= RES_NONE;
                state    <= S_RESULT;
              end
            endcase
          end
        end
        S_SEED_MUL: begin
          state <= S_SEED_STEP;
        end
        S_SEED_STEP: begin
          if (k == IDX_LAST) begin
            k     <= '0;
            state <= S_CHK_ISSUE;
          end else begin
            k     <= k + 1'b1;
            state <= S_SEED_MUL;
          end
        end
        S_CHK_ISSUE: begin
          k <= k + 1'b1;
          if (k == IDX_LAST) state <= S_CHK_WAIT;
        end
        S_CHK_WAIT: begin
          if (sts.chk_done) begin
            if (sts.all_zero) begin
              res_kind <= RES_STUCK;
              state    <= S_RESULT;
            end else begin
              uni    <= 1'b1;
              second <= 1'b0;
              state  <= S_MAC_ISSUE;
            end
          end
        end
        S_MAC_ISSUE: begin
          k <= k + 1'b1;
          if (k == IDX_LAST) state <= S_MAC_WAIT;
        end
        S_MAC_WAIT: begin
          if (sts.mac_done) begin
            priority if (!uni) begin
              res_kind <= RES_INT;
              state    <= S_RESULT;
            end else if (!second) begin
              second <= 1'b1;
              state  <= S_MAC_ISSUE;
            end else if (sts.frac_zero) begin
              second <= 1'b0;
              state  <= S_MAC_ISSUE;
            end else begin
              res_kind <= RES_UNI;
              state    <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (sts.slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mrg8_random_generator.sv
// Top level of the order-8 multiple recursive generator, modulus 2^31-1.
//
//   channel | dir | word fields                    | accepted when
//   --------+-----+--------------------------------+------------------------
//   req     | in  | opcode[1:0], seed_value[30:0]  | req.valid & req.ready
//   rsp     | out | value[52:0], is_uniform, stuck | rsp.valid & rsp.ready
//
// Sequence: an integer draw makes eight ring reads through the single read port,
//   each term through the shared 31x32 multiplier, mod-M fold and accumulate
//   (3 stage drain), then a ring write. A uniform draw adds a stuck sweep over
//   the ring and costs two integer draws per attempt; a seed adds seven
//   multiply/add steps, each a multiply state followed by a step state.
// One word in flight; req.ready is high only while idle. The result register
//   frees the input side as soon as a result is loaded.
// Reset (rst, synchronous): ring reads as all zero, pointer zero, no result.
// A stalled rsp holds its word; the next result waits until the slot frees.
`timescale 1ns / 1ps

module mrg8_random_generator
  import mrg8_pkg::*;
(
  input logic      clk,
  input logic      rst,
  mrg8_in_if.sink  req,
  mrg8_out_if.source rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: request handshake and sequencing of the datapath
  mrg8_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: ring, multiplier, accumulator and the result register
  mrg8_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .seed_value     (req.seed_value),
    .sts            (sts),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_value      (rsp.value),
    .rsp_is_uniform (rsp.is_uniform),
    .rsp_stuck      (rsp.stuck)
  );

endmodule

### rtl/mrg8_checker.sv
// Port-level assertions for the MRG8 generator, bound to the top level.
`timescale 1ns / 1ps

module mrg8_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [52:0] rsp_value,
  input logic        rsp_is_uniform,
  input logic        rsp_stuck
);

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
      $stable(rsp_is_uniform) && $stable(rsp_stuck))
    else $error("result word changed while stalled");

  // stuck flag only on a uniform result with a zero numerator
  a_stuck_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stuck |-> rsp_is_uniform && (rsp_value == 53'd0))
    else $error("stuck result malformed");

  // integer draws are reduced below the modulus
  a_int_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_is_uniform |->
      (rsp_value[52:31] == 22'd0) && (rsp_value[30:0] != 31'h7FFF_FFFF))
    else $error("integer draw not reduced");

  // zero fractions are redrawn
  a_uni_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_uniform && !rsp_stuck |-> rsp_value != 53'd0)
    else $error("uniform numerator is zero");

endmodule

bind mrg8_random_generator mrg8_checker u_mrg8_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_value      (rsp.value),
  .rsp_is_uniform (rsp.is_uniform),
  .rsp_stuck      (rsp.stuck)
);

### verif/mrg8_random_generator_tb.sv
// Self-checking testbench for the MRG8 random generator: predictor, stimulus and scoreboard.
`timescale 1ns / 1ps

module mrg8_random_generator_tb;
  import mrg8_pkg::*;

  // Run sizing. The slowest word is a seed with a retried uniform draw, and
  // receiver stalls add to it. The limit allows for several times the slowest
  // full run.
  localparam int RANDOM_WORDS = 1820;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam longint unsigned MODULUS   = 64'd2147483647;
  localparam logic [31:0]     INIT_MULT = 32'd1812433253;

  // One expected response word.
  typedef struct packed {
    logic [52:0] value;
    logic        is_uniform;
    logic        stuck;
  } draw_t;

  logic clk;
  logic rst;

  mrg8_in_if  req_if ();
  mrg8_out_if rsp_if ();

  mrg8_random_generator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // --------------------------------------------------------------------
  // Predictor state: eight history words and the pointer to the oldest.
  // --------------------------------------------------------------------
  logic [31:0] gen_ring [8];
  logic [2:0]  gen_ptr;

  draw_t pending_draws [$];

  int mismatch_count;
  int results_checked;
  int stuck_seen;
  int uniform_seen;
  int integer_seen;
  int words_sent;
  int op_count [4];
  int hold_offs_done;
  int cycle_count;

  // Sender burst shaping and the receiver hold-off request.
  int burst_left;
  bit hold_off_req;

  function automatic logic [31:0] tap_weight(input int k);
    logic [31:0] w;
    case (k)
      0:       w = 32'd1089656042;
      1:       w = 32'd1906537547;
      2:       w = 32'd1764115693;
      3:       w = 32'd1304127872;
      4:       w = 32'd189748160;
      5:       w = 32'd1984088114;
      6:       w = 32'd626062218;
      default: w = 32'd1927846343;
    endcase
    return w;
  endfunction

  // Weighted sum over the last eight words, reduced exactly mod 2^31-1.
  // Tap k pairs with the word k+1 places behind the pointer.
  function automatic logic [30:0] mrg_next_integer();
    longint unsigned acc;
    longint unsigned prod;
    logic [2:0]      idx;
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      idx  = gen_ptr - 3'(k) - 3'd1;
      prod = {32'b0, tap_weight(k)} * {32'b0, gen_ring[idx]};
      acc  = acc + (prod % MODULUS);
    end
    acc = acc % MODULUS;
    gen_ring[gen_ptr] = acc[31:0];
    gen_ptr = gen_ptr + 3'd1;
    return acc[30:0];
  endfunction

  // Words equal to the modulus or twice it count as zero here (2^31-1 and 2*(2^31-1)).
  function automatic bit mrg_ring_all_zero();
    for (int k = 0; k < 8; k++) begin
      if (({32'b0, gen_ring[k]} % MODULUS) != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // 53-bit numerator: low 23 bits of the first draw over low 30 of the second;
  // an all-zero pair is drawn again.
  function automatic logic [52:0] mrg_next_uniform(output logic stuck_flag);
    logic [30:0] hi;
    logic [30:0] lo;
    logic [59:0] pair;
    if (mrg_ring_all_zero()) begin
      stuck_flag = 1'b1;
      return '0;
    end
    stuck_flag = 1'b0;
    do begin
      hi   = mrg_next_integer();
      lo   = mrg_next_integer();
      pair = {hi[29:0], lo[29:0]};
    end while (pair[52:0] == '0);
    return pair[52:0];
  endfunction

  // Seeding recurrence, 32-bit wrap; later words may land at or above M.
  function automatic void mrg_seed_ring(input logic [30:0] seed);
    logic [31:0] w;
    gen_ring[0] = {1'b0, seed};
    for (int k = 1; k < 8; k++) begin
      w = gen_ring[k-1];
      gen_ring[k] = INIT_MULT * (w ^ (w >> 30)) + 32'(k);
    end
    gen_ptr = 3'd0;
  endfunction

  function automatic draw_t predict_response(input op_t op, input logic [30:0] seed);
    draw_t r;
    logic  stk;
    r = '0;
    case (op)
      OP_SEED: begin
        mrg_seed_ring(seed);
        r.value      = mrg_next_uniform(stk);
        r.is_uniform = 1'b1;
        r.stuck      = stk;
      end
      OP_INT: begin
        r.value = {22'b0, mrg_next_integer()};
      end
      OP_UNI: begin
        r.value      = mrg_next_uniform(stk);
        r.is_uniform = 1'b1;
        r.stuck      = stk;
      end
      default: begin
        // unused opcode: zero word, state untouched
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------
  // Sender: offers one request word and holds it until accepted. Words go
  // out in bursts; when a burst runs out, valid drops for a random gap.
  // Valid is never lowered and raised in the same step.
  // --------------------------------------------------------------------
  task automatic issue_request(input op_t op, input logic [30:0] seed);
    int gap_len;
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.seed_value <= seed;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_draws.push_back(predict_response(op, seed));
    words_sent++;
    op_count[op]++;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 15);
      gap_len = $urandom_range(1, 40);
      req_if.valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_all_results();
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------
  // Receiver: ready follows a pattern of its own, switching between always
  // ready, random stalls and a fixed duty cycle. On request it holds off for
  // HOLD_CYCLES so the result slot and the engine both fill up.
  // --------------------------------------------------------------------
  initial begin : receiver
    int  mode;
    int  mode_left;
    int  phase;
    logic nxt;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_offs_done++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      case (mode)
        0:       nxt = 1'b1;
        1:       nxt = ($urandom_range(0, 99) < 55);
        default: nxt = ((phase % 7) < 4);
      endcase
      rsp_if.ready <= nxt;
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------
  // Scoreboard: each accepted response word against the oldest prediction.
  // --------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    draw_t exp_word;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected response word: value %0d is_uniform %0b stuck %0b",
               rsp_if.value, rsp_if.is_uniform, rsp_if.stuck);
        mismatch_count++;
      end else begin
        exp_word = pending_draws.pop_front();
        results_checked++;
        if (rsp_if.value !== exp_word.value) begin
          $error("value: expected %0d, actual %0d", exp_word.value, rsp_if.value);
          mismatch_count++;
        end
        if (rsp_if.is_uniform !== exp_word.is_uniform) begin
          $error("is_uniform: expected %0b, actual %0b",
                 exp_word.is_uniform, rsp_if.is_uniform);
          mismatch_count++;
        end
        if (rsp_if.stuck !== exp_word.stuck) begin
          $error("stuck: expected %0b, actual %0b", exp_word.stuck, rsp_if.stuck);
          mismatch_count++;
        end
        if (exp_word.stuck) stuck_seen++;
        else if (exp_word.is_uniform) uniform_seen++;
        else integer_seen++;
      end
    end
  end

  // --------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run aborted after %0d cycles, %0d words still pending",
             cycle_count, pending_draws.size());
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------

  // Out of reset the ring is all zero: uniform draws report stuck, an
  // integer draw gives 0 and leaves the ring zero, the unused opcode gives
  // a zero word.
  task automatic test_stuck_after_reset();
    issue_request(OP_UNI, 31'd0);
    issue_request(OP_INT, 31'd0);
    issue_request(OP_NONE, 31'h7FFF_FFFF);
    issue_request(OP_UNI, 31'h5555_5555);
  endtask

  // Seed extremes and the bit-30 boundary of the seeding shift. Several of
  // these leave history words at or above the modulus.
  task automatic test_seed_extremes();
    issue_request(OP_SEED, 31'd0);
    issue_request(OP_INT, 31'd0);
    issue_request(OP_SEED, 31'h7FFF_FFFF);
    issue_request(OP_UNI, 31'd0);
    issue_request(OP_SEED, 31'h4000_0000);
    issue_request(OP_SEED, 31'h3FFF_FFFF);
  endtask

  // Unused opcode on a live ring must not disturb the sequence.
  task automatic test_unused_opcode();
    issue_request(OP_NONE, 31'h2AAA_AAAA);
    issue_request(OP_INT, 31'd0);
  endtask

  // A seed, whose uniform draw takes two words, then eight integer draws so the pointer wraps past the seed words.
  task automatic test_pointer_wrap();
    issue_request(OP_SEED, 31'd1);
    for (int n = 0; n < 8; n++) issue_request(OP_INT, 31'($urandom()));
  endtask

  // Mostly draws on a seeded ring with occasional reseeds; unused opcodes
  // are sprinkled in as noise.
  task automatic test_random_mix(input int count);
    int          r;
    logic [30:0] seed;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        case ($urandom_range(0, 5))
          0:       seed = 31'd0;
          1:       seed = 31'h7FFF_FFFF;
          default: seed = 31'($urandom());
        endcase
        issue_request(OP_SEED, seed);
      end else if (r < 11) begin
        issue_request(OP_NONE, 31'($urandom()));
      end else if (r < 55) begin
        issue_request(OP_INT, 31'($urandom()));
      end else begin
        issue_request(OP_UNI, 31'($urandom()));
      end
    end
  endtask

  // Receiver goes quiet for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      issue_request(($urandom_range(0, 1) == 0) ? OP_INT : OP_UNI, 31'($urandom()));
    end
  endtask

  // Sender stops until every outstanding response has come back.
  task automatic test_sender_pause();
    req_if.valid <= 1'b0;
    wait_all_results();
    @(posedge clk);
    issue_request(OP_SEED, 31'($urandom()));
    issue_request(OP_UNI, 31'd0);
  endtask

  // --------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------
  initial begin : main
    mismatch_count  = 0;
    results_checked = 0;
    stuck_seen      = 0;
    uniform_seen    = 0;
    integer_seen    = 0;
    words_sent      = 0;
    hold_offs_done  = 0;
    hold_off_req    = 1'b0;
    burst_left      = 4;
    for (int k = 0; k < 4; k++) op_count[k] = 0;
    for (int k = 0; k < 8; k++) gen_ring[k] = '0;
    gen_ptr = '0;

    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.opcode     <= OP_NONE;
    req_if.seed_value <= '0;
    rsp_if.ready      <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_stuck_after_reset();
    test_seed_extremes();
    test_unused_opcode();
    test_pointer_wrap();
    test_random_mix(RANDOM_WORDS / 2);
    test_backpressure();
    test_sender_pause();
    test_random_mix(RANDOM_WORDS - RANDOM_WORDS / 2);

    // drain, then give the engine time to show any stray word
    req_if.valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d request words: %0d seed, %0d integer, %0d uniform, %0d unused",
             words_sent, op_count[OP_SEED], op_count[OP_INT], op_count[OP_UNI],
             op_count[OP_NONE]);
    $display("Checked %0d responses (%0d integer, %0d uniform, %0d stuck), %0d long hold-offs",
             results_checked, integer_seen, uniform_seen, stuck_seen, hold_offs_done);
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
